### hw/rtl/ss8_pkg.sv
package ss8_pkg;

    localparam int MAX_STEPS   = 8;
    localparam int STEP_BITS   = $clog2(MAX_STEPS);
    localparam int COUNT_BITS  = 4;
    localparam int PHASE_BITS  = 32;
    localparam int INC_BITS    = 32;
    localparam int LEVEL_BITS  = 8;
    localparam int ROW_BITS    = 64;
    localparam int CFG_IDX_BITS = 2;
    localparam int IN_DATA_BITS  = 48;
    localparam int OUT_DATA_BITS = 48;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ROW_ONE   = 2'd0,
        REG_ROW_TWO   = 2'd1,
        REG_ROW_THREE = 2'd2
    } ss8_cfg_reg_t;

    // members listed from the highest bit down
    typedef struct packed {
        logic [INC_BITS-1:0]   phase_increment;
        logic [MAX_STEPS-1:0]  gate_buttons;
        logic [COUNT_BITS-1:0] step_count;
        logic                  reset_level;
        logic                  ext_clock_level;
        logic                  ext_clock_connected;
        logic                  run_button;
    } ss8_item_t;

    typedef struct packed {
        logic [MAX_STEPS-1:0]  gate_memory;
        logic                  is_running;
        logic [LEVEL_BITS-1:0] row_three_level;
        logic [LEVEL_BITS-1:0] row_two_level;
        logic [LEVEL_BITS-1:0] row_one_level;
        logic                  gates_active;
        logic [MAX_STEPS-1:0]  gate_enables;
        logic [STEP_BITS-1:0]  step_index;
    } ss8_result_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] row_one;
        logic [ROW_BITS-1:0] row_two;
        logic [ROW_BITS-1:0] row_three;
    } ss8_rows_t;

endpackage

### hw/rtl/ss8_core.sv
module ss8_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  ss8_pkg::ss8_item_t   item,
    input  ss8_pkg::ss8_rows_t   rows,
    output ss8_pkg::ss8_result_t result
);

    logic                               running_reg, running_next;
    logic [ss8_pkg::PHASE_BITS-1:0]     phase_reg, phase_next;
    logic [ss8_pkg::STEP_BITS-1:0]      step_reg, step_next;
    logic [ss8_pkg::MAX_STEPS-1:0]      gates_reg, gates_next;
    logic                               prev_run_reg;
    logic                               prev_clk_reg, prev_clk_next;
    logic                               prev_rst_reg;
    logic [ss8_pkg::MAX_STEPS-1:0]      prev_btn_reg;

    logic                               run_edge;
    logic                               clk_edge;
    logic                               rst_edge;
    logic                               use_accum;
    logic [ss8_pkg::PHASE_BITS:0]       sum;
    logic                               carry;
    logic                               advance;
    logic [ss8_pkg::COUNT_BITS-1:0]     count;
    logic [ss8_pkg::STEP_BITS:0]        step_inc;
    logic                               gate_on;

    always_comb begin
        run_edge     = item.run_button && !prev_run_reg;
        running_next = running_reg ^ run_edge;

        clk_edge      = running_next && item.ext_clock_connected &&
                        item.ext_clock_level && !prev_clk_reg;
        prev_clk_next = (running_next && item.ext_clock_connected) ?
                        item.ext_clock_level : prev_clk_reg;

        use_accum = running_next && !item.ext_clock_connected;
        sum       = {1'b0, phase_reg} + {1'b0, item.phase_increment};
        carry     = use_accum && sum[ss8_pkg::PHASE_BITS];

        rst_edge = item.reset_level && !prev_rst_reg;

        if (rst_edge || clk_edge) begin
            phase_next = '0;
        end else if (use_accum) begin
            phase_next = sum[ss8_pkg::PHASE_BITS-1:0];
        end else begin
            phase_next = phase_reg;
        end

        advance = clk_edge || carry || rst_edge;

        if (item.step_count == '0) begin
            count = ss8_pkg::COUNT_BITS'(1);
        end else if (item.step_count > ss8_pkg::COUNT_BITS'(ss8_pkg::MAX_STEPS)) begin
            count = ss8_pkg::COUNT_BITS'(ss8_pkg::MAX_STEPS);
        end else begin
            count = item.step_count;
        end

        step_inc = {1'b0, step_reg} + 1'b1;
        priority if (rst_edge) begin
            step_next = '0;
        end else if (advance) begin
            step_next = (ss8_pkg::COUNT_BITS'(step_inc) >= count) ?
                        '0 : step_inc[ss8_pkg::STEP_BITS-1:0];
        end else begin
            step_next = step_reg;
        end

        gates_next = gates_reg ^ (item.gate_buttons & ~prev_btn_reg);
        gate_on    = gates_next[step_next];

        result.step_index      = step_next;
        result.gate_enables    = gate_on ?
                                 (ss8_pkg::MAX_STEPS'(1) << step_next) : '0;
        result.gates_active    = gate_on && !advance;
        result.row_one_level   = rows.row_one[step_next*ss8_pkg::LEVEL_BITS +:
                                              ss8_pkg::LEVEL_BITS];
        result.row_two_level   = rows.row_two[step_next*ss8_pkg::LEVEL_BITS +:
                                              ss8_pkg::LEVEL_BITS];
        result.row_three_level = rows.row_three[step_next*ss8_pkg::LEVEL_BITS +:
                                                ss8_pkg::LEVEL_BITS];
        result.is_running      = running_next;
        result.gate_memory     = gates_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg  <= 1'b1;
            phase_reg    <= '0;
            step_reg     <= '0;
            gates_reg    <= '0;
            prev_run_reg <= 1'b1;
            prev_clk_reg <= 1'b1;
            prev_rst_reg <= 1'b1;
            prev_btn_reg <= '1;
        end else if (en) begin
            running_reg  <= running_next;
            phase_reg    <= phase_next;
            step_reg     <= step_next;
            gates_reg    <= gates_next;
            prev_run_reg <= item.run_button;
            prev_clk_reg <= prev_clk_next;
            prev_rst_reg <= item.reset_level;
            prev_btn_reg <= item.gate_buttons;
        end
    end

endmodule

### hw/rtl/step_sequencer_8_step_top.sv
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata: one tick item
// m_        out  m_tvalid/m_tready  m_tdata: one result per tick
// cfg_      in   cfg_wr_en          cfg_index, cfg_wr_data: row level registers
//
// one transfer in and one out per cycle sustained while m_tready stays high;
// a result reaches m_ through the input register, then the result register
// aresetn is synchronous, active low; clears sequencer state, valid flags, rows
// a stalled m_ side holds the result while one more item waits in the
// input register; s_tready drops only when both stages are full
module step_sequencer_8_step_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // run_button, ext_clock_connected, ext_clock_level, reset_level,
    // step_count[3:0], gate_buttons[7:0], phase_increment[31:0]
    input  logic [ss8_pkg::IN_DATA_BITS-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // step_index[2:0], gate_enables[7:0], gates_active, row_one_level[7:0],
    // row_two_level[7:0], row_three_level[7:0], is_running, gate_memory[7:0], pad
    output logic [ss8_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [ss8_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ss8_pkg::ROW_BITS-1:0]        cfg_wr_data
);

    logic                  in_valid_reg, in_valid_next;
    ss8_pkg::ss8_item_t    item_reg;
    logic                  out_valid_reg, out_valid_next;
    ss8_pkg::ss8_result_t  out_reg;
    ss8_pkg::ss8_rows_t    rows_reg;
    ss8_pkg::ss8_result_t  core_result;
    logic                  stage2_ready;
    logic                  s_fire;
    logic                  core_fire;

    always_comb begin
        stage2_ready = !out_valid_reg || m_tready;
        s_tready     = !in_valid_reg || stage2_ready;
        s_fire       = s_tvalid && s_tready;
        core_fire    = in_valid_reg && stage2_ready;

        priority if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (core_fire) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        priority if (core_fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rows_reg      <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    ss8_pkg::REG_ROW_ONE:   rows_reg.row_one   <= cfg_wr_data;
                    ss8_pkg::REG_ROW_TWO:   rows_reg.row_two   <= cfg_wr_data;
                    ss8_pkg::REG_ROW_THREE: rows_reg.row_three <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= ss8_pkg::ss8_item_t'(s_tdata);
        end
        if (core_fire) begin
            out_reg <= core_result;
        end
    end

    ss8_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (core_fire),
        .item    (item_reg),
        .rows    (rows_reg),
        .result  (core_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = ss8_pkg::OUT_DATA_BITS'(out_reg);

    a_gate_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0(out_reg.gate_enables))
        else $error("gate_enables has more than one bit set");

    a_gate_at_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.gate_enables != '0) |->
        out_reg.gate_enables == (ss8_pkg::MAX_STEPS'(1) << out_reg.step_index))
        else $error("gate_enables bit not at step_index");

    a_active_has_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.gates_active) |-> out_reg.gate_enables != '0)
        else $error("gates_active without an enabled gate");

    a_stall_keeps_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !stage2_ready) |=> (in_valid_reg && $stable(item_reg)))
        else $error("pending item lost while result stage stalled");

endmodule

### tb/sv/step_sequencer_8_step_checker.sv
`timescale 1ns / 100ps

import ss8_pkg::*;

module step_sequencer_8_step_checker (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [OUT_DATA_BITS-1:0] m_tdata,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ROW_BITS-1:0]      cfg_wr_data,
    output int                       pending_results,
    output int                       fail_count
);

    ss8_result_t           tick_outputs [$];
    ss8_rows_t             rows;
    logic                  running;
    logic [PHASE_BITS-1:0] phase;
    int                    step;
    logic [MAX_STEPS-1:0]  gate_bits;
    logic                  prev_run;
    logic                  prev_clk;
    logic                  prev_rst;
    logic [MAX_STEPS-1:0]  prev_buttons;
    int                    mismatches = 0;
    int                    result_no = 0;

    task automatic report_mismatch(input string msg);
        $display("result %0d: %s", result_no, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    task automatic run_sequencer_tick(input ss8_item_t tick, output ss8_result_t res);
        logic                adv;
        logic [PHASE_BITS:0] sum;
        int                  count;
        logic                gate_on;
        adv = 1'b0;
        if (tick.run_button && !prev_run) begin
            running = !running;
        end
        prev_run = tick.run_button;
        if (running) begin
            if (tick.ext_clock_connected) begin
                if (tick.ext_clock_level && !prev_clk) begin
                    phase = '0;
                    adv = 1'b1;
                end
                prev_clk = tick.ext_clock_level;
            end else begin
                sum = {1'b0, phase} + {1'b0, tick.phase_increment};
                adv = sum[PHASE_BITS];
                phase = sum[PHASE_BITS-1:0];
            end
        end
        // reset edge acts even while stopped
        if (tick.reset_level && !prev_rst) begin
            phase = '0;
            step = MAX_STEPS;
            adv = 1'b1;
        end
        prev_rst = tick.reset_level;
        if (adv) begin
            count = int'(tick.step_count);
            if (count < 1) begin
                count = 1;
            end
            if (count > MAX_STEPS) begin
                count = MAX_STEPS;
            end
            step++;
            if (step >= count) begin
                step = 0;
            end
        end
        gate_bits = gate_bits ^ (tick.gate_buttons & ~prev_buttons);
        prev_buttons = tick.gate_buttons;
        gate_on = (step < MAX_STEPS) && gate_bits[step];
        res = '0;
        res.step_index = step[STEP_BITS-1:0];
        if (gate_on) begin
            res.gate_enables[step] = 1'b1;
        end
        res.gates_active = gate_on && !adv;
        res.row_one_level = rows.row_one[step*LEVEL_BITS +: LEVEL_BITS];
        res.row_two_level = rows.row_two[step*LEVEL_BITS +: LEVEL_BITS];
        res.row_three_level = rows.row_three[step*LEVEL_BITS +: LEVEL_BITS];
        res.is_running = running;
        res.gate_memory = gate_bits;
    endtask

    always @(posedge aclk) begin : watch
        ss8_item_t   tick_in;
        ss8_result_t want;
        ss8_result_t got;
        if (!aresetn) begin
            rows = '0;
            running = 1'b1;
            phase = '0;
            step = 0;
            gate_bits = '0;
            prev_run = 1'b1;
            prev_clk = 1'b1;
            prev_rst = 1'b1;
            prev_buttons = '1;
            tick_outputs.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(ss8_result_t)-1:0];
                if (tick_outputs.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0h", got));
                end else begin
                    want = tick_outputs.pop_front();
                    check_field("step_index", 8'(got.step_index), 8'(want.step_index));
                    check_field("gate_enables", got.gate_enables, want.gate_enables);
                    check_field("gates_active", 8'(got.gates_active), 8'(want.gates_active));
                    check_field("row_one_level", got.row_one_level, want.row_one_level);
                    check_field("row_two_level", got.row_two_level, want.row_two_level);
                    check_field("row_three_level", got.row_three_level,
                                want.row_three_level);
                    check_field("is_running", 8'(got.is_running), 8'(want.is_running));
                    check_field("gate_memory", got.gate_memory, want.gate_memory);
                end
                result_no++;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ROW_ONE: begin
                        rows.row_one = cfg_wr_data;
                    end
                    REG_ROW_TWO: begin
                        rows.row_two = cfg_wr_data;
                    end
                    REG_ROW_THREE: begin
                        rows.row_three = cfg_wr_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                tick_in = s_tdata;
                run_sequencer_tick(tick_in, want);
                tick_outputs.push_back(want);
            end
        end
        pending_results <= tick_outputs.size();
        fail_count <= mismatches;
    end

endmodule

### tb/sv/tb_step_sequencer_8_step_top.sv
`timescale 1ns / 100ps

import ss8_pkg::*;

module tb_step_sequencer_8_step_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_TICKS = 260;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [ROW_BITS-1:0]      cfg_wr_data = '0;

    int        pending_results;
    int        fail_count;
    int        cycles = 0;
    bit        tx_gaps = 1'b1;
    bit        rx_gaps = 1'b1;
    ss8_item_t levels = '0;

    step_sequencer_8_step_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    step_sequencer_8_step_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .pending_results (pending_results),
        .fail_count      (fail_count)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("step_sequencer_8_step_top regression: fail");
            $finish;
        end
    end

    function automatic ss8_item_t tick_of(input logic run, input logic conn,
                                          input logic clk, input logic rst,
                                          input logic [3:0] cnt, input logic [7:0] btn,
                                          input logic [31:0] inc);
        ss8_item_t t;
        t.run_button = run;
        t.ext_clock_connected = conn;
        t.ext_clock_level = clk;
        t.reset_level = rst;
        t.step_count = cnt;
        t.gate_buttons = btn;
        t.phase_increment = inc;
        return t;
    endfunction

    task automatic send_tick(input ss8_item_t t);
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= t;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
    endtask

    task automatic load_rows(input logic [ROW_BITS-1:0] one, input logic [ROW_BITS-1:0] two,
                             input logic [ROW_BITS-1:0] three);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_ROW_ONE;
        cfg_wr_data <= one;
        @(posedge aclk);
        cfg_index <= REG_ROW_TWO;
        cfg_wr_data <= two;
        @(posedge aclk);
        cfg_index <= REG_ROW_THREE;
        cfg_wr_data <= three;
        @(posedge aclk);
        // unused index, must not disturb the rows
        cfg_index <= REG_SPARE;
        cfg_wr_data <= {$urandom, $urandom};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drift_levels(output ss8_item_t t);
        if ($urandom_range(0, 9) == 0) begin
            t = {16'($urandom), 32'($urandom)};
        end else begin
            if ($urandom_range(0, 39) == 0) begin
                levels.run_button = !levels.run_button;
            end
            if ($urandom_range(0, 59) == 0) begin
                levels.ext_clock_connected = !levels.ext_clock_connected;
            end
            if ($urandom_range(0, 2) == 0) begin
                levels.ext_clock_level = !levels.ext_clock_level;
            end
            if ($urandom_range(0, 49) == 0) begin
                levels.reset_level = !levels.reset_level;
            end
            if ($urandom_range(0, 19) == 0) begin
                levels.step_count = 4'($urandom_range(0, 15));
            end
            if ($urandom_range(0, 5) == 0) begin
                levels.gate_buttons = levels.gate_buttons ^ 8'(1 << $urandom_range(0, 7));
            end
            if ($urandom_range(0, 29) == 0) begin
                case ($urandom_range(0, 3))
                    0: begin
                        levels.phase_increment = $urandom;
                    end
                    1: begin
                        levels.phase_increment = 32'hFFFF_FFFF - $urandom_range(0, 15);
                    end
                    2: begin
                        levels.phase_increment = $urandom >> $urandom_range(1, 31);
                    end
                    default: begin
                        levels.phase_increment = 32'h8000_0000 + $urandom_range(0, 255);
                    end
                endcase
            end
            t = levels;
        end
    endtask

    initial begin
        @(posedge aclk);
        forever begin
            if (rx_gaps && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin
        ss8_item_t t;
        int        ph;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_rows(64'h8877_6655_4433_2211, 64'hF7E6_D5C4_B3A2_9180,
                  64'h0123_4567_89AB_CDEF);
        // first high levels after reset are not edges
        send_tick(tick_of(1, 0, 1, 1, 4'd8, 8'hFF, 32'h0));
        send_tick(tick_of(0, 0, 0, 0, 4'd8, 8'h00, 32'h0));
        // stop, clock ignored while stopped, reset still acts
        send_tick(tick_of(1, 0, 0, 0, 4'd8, 8'h00, 32'h0));
        send_tick(tick_of(0, 1, 1, 0, 4'd8, 8'h00, 32'h0));
        send_tick(tick_of(0, 1, 0, 1, 4'd8, 8'h00, 32'h0));
        send_tick(tick_of(1, 1, 0, 0, 4'd8, 8'hFF, 32'h0));
        // external clock edges
        send_tick(tick_of(0, 1, 1, 0, 4'd8, 8'h00, 32'h0));
        send_tick(tick_of(0, 1, 0, 0, 4'd8, 8'h55, 32'h0));
        send_tick(tick_of(0, 1, 1, 0, 4'd8, 8'h00, 32'h0));
        send_tick(tick_of(0, 1, 0, 0, 4'd8, 8'h00, 32'h0));
        send_tick(tick_of(0, 1, 1, 0, 4'd8, 8'h00, 32'h0));
        send_tick(tick_of(0, 1, 0, 0, 4'd8, 8'h00, 32'h0));
        send_tick(tick_of(0, 1, 1, 0, 4'd8, 8'h00, 32'h0));
        // index beyond a shrunk count wraps to zero
        send_tick(tick_of(0, 1, 0, 0, 4'd3, 8'h00, 32'h0));
        send_tick(tick_of(0, 1, 1, 0, 4'd3, 8'h00, 32'h0));
        // count of zero and above eight
        send_tick(tick_of(0, 1, 0, 0, 4'd0, 8'h00, 32'h0));
        send_tick(tick_of(0, 1, 1, 0, 4'd0, 8'h00, 32'h0));
        send_tick(tick_of(0, 1, 0, 0, 4'd15, 8'h00, 32'h0));
        send_tick(tick_of(0, 1, 1, 0, 4'd15, 8'h00, 32'h0));
        // internal accumulator carries
        send_tick(tick_of(0, 0, 0, 0, 4'd15, 8'h00, 32'hFFFF_FFFF));
        send_tick(tick_of(0, 0, 0, 0, 4'd15, 8'h00, 32'hFFFF_FFFF));
        send_tick(tick_of(0, 0, 0, 0, 4'd15, 8'h00, 32'h8000_0000));
        send_tick(tick_of(0, 0, 0, 0, 4'd15, 8'h00, 32'h8000_0000));
        // reset edge while running
        send_tick(tick_of(0, 0, 0, 1, 4'd15, 8'hAA, 32'h0000_0001));
        send_tick(tick_of(0, 0, 0, 0, 4'd15, 8'h00, 32'h0));

        levels = tick_of(0, 0, 0, 0, 4'd8, 8'h00, 32'h2000_0000);
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    load_rows('0, '0, '0);
                end
                1: begin
                    load_rows('1, '1, '1);
                end
                3: begin
                    load_rows(64'h00FF_00FF_00FF_00FF, 64'hFF00_FF00_FF00_FF00,
                              64'h8001_4002_2004_1008);
                end
                default: begin
                    load_rows({$urandom, $urandom}, {$urandom, $urandom},
                              {$urandom, $urandom});
                end
            endcase
            if (ph == 5) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            repeat (PHASE_TICKS) begin
                drift_levels(t);
                send_tick(t);
            end
        end

        wait_drained();
        repeat (4) @(posedge aclk);
        if (fail_count == 0) begin
            $display("step_sequencer_8_step_top regression: pass");
        end else begin
            $display("step_sequencer_8_step_top regression: fail");
        end
        $finish;
    end

endmodule

### step_sequencer_8_step_top.f
hw/rtl/ss8_pkg.sv
hw/rtl/ss8_core.sv
hw/rtl/step_sequencer_8_step_top.sv
tb/sv/step_sequencer_8_step_checker.sv
tb/sv/tb_step_sequencer_8_step_top.sv
